/* rtl/core/sst_pkg.sv */
// Package for the sorted set table: sizes, codes and beat types.
package sst_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } sst_state_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [KEY_W-1:0] key;
    } sst_in_t;

    typedef struct packed {
        logic               success;
        logic [1:0]         status;
        logic [ENTRY_W-1:0] entry_count;
    } sst_out_t;

    typedef struct packed {
        logic ins;
        logic del;
    } sst_ctl_t;

endpackage

/* rtl/core/sst_cell.sv */
// One slot of the sorted row: holds a key, compares it and shifts with its neighbours.
module sst_cell
    import sst_pkg::*;
(
    input  logic                    clk,
    input  logic                    valid,
    input  logic signed [KEY_W-1:0] probe,
    input  sst_ctl_t                ctl,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic signed [KEY_W-1:0] right_key,
    output logic                    lt,
    output logic                    eq,
    output logic signed [KEY_W-1:0] key
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign lt  = valid && (key_reg < probe);
    assign eq  = valid && (key_reg == probe);
    assign key = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins && !lt)
        begin
            key_next = left_lt ? probe : left_key;
        end
        else if (ctl.del && !lt)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

/* rtl/core/sorted_set_table.sv */
// Top level of the sorted set table: command capture, cell row and result beat.
//
//  port    dir  width  role
//  start   in   1      command strobe, taken when busy is low
//  cmd     in   34     mode and key of the command beat
//  busy    out  1      command in flight
//  done    out  1      result beat strobe, one cycle
//  result  out  8      success, status and entry count
//
// Each command is first captured into op_reg; then, in ST_EXEC, the cell row
// compares, shifts and registers the result. done rises the cycle after that.
// A new command may be taken in the cycle done is high.
// Reset empties the set at once; no clearing pass.
// The receiver cannot stall the result beat.
module sorted_set_table
    import sst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  sst_in_t  cmd,
    output logic     busy,
    output logic     done,
    output sst_out_t result
);

    sst_state_t state_reg, state_next;
    sst_in_t    op_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic       done_reg, done_next;
    sst_out_t   result_reg, result_next;
    sst_ctl_t   ctl;

    logic                    cell_lt  [CAPACITY];
    logic                    cell_eq  [CAPACITY];
    logic signed [KEY_W-1:0] cell_key [CAPACITY];

    logic present;
    logic full;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    left_lt;
            logic signed [KEY_W-1:0] left_key;
            logic signed [KEY_W-1:0] right_key;

            if (gi == 0)
            begin : g_first
                assign left_lt  = 1'b1;
                assign left_key = op_reg.key;
            end
            else
            begin : g_mid
                assign left_lt  = cell_lt[gi-1];
                assign left_key = cell_key[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key = cell_key[gi];
            end
            else
            begin : g_inner
                assign right_key = cell_key[gi+1];
            end

            sst_cell u_cell (
                .clk       (clk),
                .valid     (count_reg > CNT_W'(gi)),
                .probe     (op_reg.key),
                .ctl       (ctl),
                .left_lt   (left_lt),
                .left_key  (left_key),
                .right_key (right_key),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi]),
                .key       (cell_key[gi])
            );
        end
    endgenerate

    always_comb
    begin
        present = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            present = present | cell_eq[i];
        end
    end

    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next          = ST_IDLE;
                done_next           = 1'b1;
                result_next.success = 1'b0;
                result_next.status  = STATUS_DONE;
                case (op_reg.mode)
                    MODE_INSERT:
                    begin
                        if (present)
                        begin
                            result_next.status = STATUS_ABSENT;
                        end
                        else if (full)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            ctl.ins             = 1'b1;
                            count_next          = count_reg + CNT_W'(1);
                            result_next.success = 1'b1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (present)
                        begin
                            ctl.del             = 1'b1;
                            count_next          = count_reg - CNT_W'(1);
                            result_next.success = 1'b1;
                        end
                        else
                        begin
                            result_next.status = STATUS_ABSENT;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        result_next.success = present;
                        result_next.status  = present ? STATUS_DONE : STATUS_ABSENT;
                    end
                    default:
                    begin
                    end
                endcase
                result_next.entry_count = ENTRY_W'(count_next);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (state_reg == ST_IDLE && start)
        begin
            op_reg <= cmd;
        end
    end

    assign busy   = (state_reg == ST_EXEC);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("command did not complete in one cycle");

    a_count_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done)
        else $error("entry count changed without a result beat");

    a_success_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.success |-> result.status == STATUS_DONE)
        else $error("success beat carries a failure status");

endmodule
